>>> hw/rtl/text_frame_diff_renderer_unit_assert.svh
// assertion macros for the text frame renderer
`ifndef TEXT_FRAME_DIFF_RENDERER_UNIT_ASSERT_SVH
`define TEXT_FRAME_DIFF_RENDERER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TFDR_ASSERT_IMPL(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TFDR_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define TFDR_ASSERT_IMPL(label, prop, msg)
`define TFDR_ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> hw/rtl/tfdr_pkg.sv
// shared types and constants for the text frame renderer
package tfdr_pkg;
   localparam int MaxCols = 32;
   localparam int MaxRows = 32;
   localparam int ColW = $clog2(MaxCols);
   localparam int RowW = $clog2(MaxRows);
   localparam int AddrW = ColW + RowW;
   localparam int CellCount = MaxCols * MaxRows;
   localparam logic [7:0] BlankChar = 8'h20;
   localparam logic [7:0] ClearChar = 8'h2E;
   localparam logic [2:0] RegActiveCols = 3'd0;
   localparam logic [2:0] RegActiveRows = 3'd1;
   localparam int QDepth = 2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DRAW, ST_CMP, ST_EMIT, ST_WIPE
   } be_state_type;

   // classified job from front to back
   typedef struct packed {
      logic is_render;
      logic [ColW:0] x0;
      logic [ColW:0] x1;
      logic [RowW:0] y0;
      logic [RowW:0] y1;
      logic [7:0] symbol;
      logic [7:0] row;
      logic [ColW:0] cols;
   } job_type;
endpackage

>>> hw/rtl/tfdr_req_if.sv
// request and response channel interfaces
interface tfdr_req_if;
   logic valid;
   logic ready;
   logic command;
   logic signed [10:0] rect_x;
   logic signed [10:0] rect_y;
   logic [9:0] rect_w;
   logic [9:0] rect_h;
   logic [7:0] symbol;
   logic [7:0] row;
   modport source (output valid, command, rect_x, rect_y, rect_w, rect_h, symbol, row,
                   input ready);
   modport sink (input valid, command, rect_x, rect_y, rect_w, rect_h, symbol, row,
                 output ready);
endinterface

interface tfdr_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_row;
   logic [5:0] out_col;
   logic [7:0] out_char;
   logic last;
   modport source (output valid, out_row, out_col, out_char, last, input ready);
   modport sink (input valid, out_row, out_col, out_char, last, output ready);
endinterface

>>> hw/rtl/tfdr_front.sv
// front end: clips rectangles and classifies items into jobs
module tfdr_front (
   input  logic clock,
   input  logic reset,
   tfdr_req_if.sink req,
   input  logic [6:0] active_cols,
   input  logic [8:0] active_rows,
   output logic job_valid,
   input  logic job_ready,
   output tfdr_pkg::job_type job
);
   localparam int CW = tfdr_pkg::ColW;
   localparam int RW = tfdr_pkg::RowW;
   tfdr_pkg::job_type q_ff [tfdr_pkg::QDepth];
   tfdr_pkg::job_type q_in [tfdr_pkg::QDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic [CW:0] cols;
   logic [RW:0] rows;
   logic signed [12:0] xs, xe, ys, ye;
   tfdr_pkg::job_type nj;
   logic push, pop;

   always_comb begin
      cols = (active_cols < 7'(tfdr_pkg::MaxCols)) ? active_cols[CW:0] : (CW+1)'(tfdr_pkg::MaxCols);
      rows = (active_rows < 9'(tfdr_pkg::MaxRows)) ? active_rows[RW:0] : (RW+1)'(tfdr_pkg::MaxRows);
      xs = 13'(req.rect_x);
      ys = 13'(req.rect_y);
      xe = xs + 13'($signed({1'b0, req.rect_w}));
      ye = ys + 13'($signed({1'b0, req.rect_h}));
      nj.is_render = req.command;
      nj.symbol = req.symbol;
      nj.row = req.row;
      nj.cols = cols;
      nj.x0 = xs < 0 ? '0 : (xs > 13'($signed({1'b0, cols})) ? cols : xs[CW:0]);
      nj.x1 = xe < 0 ? '0 : (xe > 13'($signed({1'b0, cols})) ? cols : xe[CW:0]);
      nj.y0 = ys < 0 ? '0 : (ys > 13'($signed({1'b0, rows})) ? rows : ys[RW:0]);
      nj.y1 = ye < 0 ? '0 : (ye > 13'($signed({1'b0, rows})) ? rows : ye[RW:0]);
      // out-of-range render becomes an empty job
      if (req.command && {1'b0, req.row} >= 9'(rows)) begin
         nj.is_render = 1'b0;
         nj.y0 = '0;
         nj.y1 = '0;
      end
   end

   assign req.ready = cnt_ff < 2'(tfdr_pkg::QDepth);
   assign push = req.valid && req.ready;
   assign job_valid = cnt_ff != 2'd0;
   assign pop = job_valid && job_ready;
   assign job = q_ff[0];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_comb begin
      q_in = q_ff;
      if (pop) q_in[0] = q_ff[1];
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) q_in[0] = nj;
         else q_in[1] = nj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

>>> hw/rtl/tfdr_back.sv
// back end: executes draw and render jobs on the two cell memories
module tfdr_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  tfdr_pkg::job_type job,
   tfdr_rsp_if.source rsp,
   output logic busy
);
   localparam int CW = tfdr_pkg::ColW;
   localparam int RW = tfdr_pkg::RowW;
   localparam int AW = tfdr_pkg::AddrW;
   logic [7:0] shown_mem [tfdr_pkg::CellCount];
   logic [7:0] draw_mem [tfdr_pkg::CellCount];
   tfdr_pkg::be_state_type st_ff, st_in;
   tfdr_pkg::job_type j_ff;
   logic [CW:0] c_ff, c_in;
   logic [RW:0] r_ff, r_in;
   logic [AW:0] clr_ff;
   logic diff_ff, diff_in;
   logic rdv_ff;
   logic [CW:0] rdc_ff;
   logic [7:0] sh_q_ff, dr_q_ff;
   logic ov_ff;
   logic [7:0] orow_ff, ochar_ff;
   logic [5:0] ocol_ff;
   logic olast_ff;
   logic out_free;
   logic [AW-1:0] addr;
   logic take;
   logic stall;
   logic emit;

   assign out_free = !ov_ff || rsp.ready;
   assign take = st_ff == tfdr_pkg::ST_IDLE && job_valid;
   assign job_ready = take;
   assign busy = st_ff != tfdr_pkg::ST_IDLE || ov_ff || rdv_ff;
   // read data waiting while the output register is full
   assign stall = st_ff == tfdr_pkg::ST_EMIT && rdv_ff && !out_free;
   assign emit = st_ff == tfdr_pkg::ST_EMIT && rdv_ff && out_free;
   assign rsp.valid = ov_ff;
   assign rsp.out_row = orow_ff;
   assign rsp.out_col = ocol_ff;
   assign rsp.out_char = ochar_ff;
   assign rsp.last = olast_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         tfdr_pkg::ST_CLEAR:
            if (clr_ff == (AW+1)'(tfdr_pkg::CellCount - 1)) st_in = tfdr_pkg::ST_IDLE;
         tfdr_pkg::ST_IDLE: if (job_valid) st_in = job.is_render ? tfdr_pkg::ST_CMP : tfdr_pkg::ST_DRAW;
         tfdr_pkg::ST_DRAW: if (j_ff.x0 >= j_ff.x1 || r_ff >= j_ff.y1 ||
                               (c_ff + 1'b1 >= j_ff.x1 && r_ff + 1'b1 >= j_ff.y1))
                               st_in = tfdr_pkg::ST_IDLE;
         tfdr_pkg::ST_CMP:
            if (c_ff >= j_ff.cols)
               st_in = (diff_ff || (rdv_ff && sh_q_ff != dr_q_ff)) ? tfdr_pkg::ST_EMIT
                                                                   : tfdr_pkg::ST_WIPE;
         tfdr_pkg::ST_EMIT: if (emit && rdc_ff + 1'b1 >= j_ff.cols) st_in = tfdr_pkg::ST_IDLE;
         tfdr_pkg::ST_WIPE: if (c_ff + 1'b1 >= j_ff.cols) st_in = tfdr_pkg::ST_IDLE;
         default: st_in = tfdr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      c_in = c_ff;
      r_in = r_ff;
      diff_in = diff_ff;
      addr = {j_ff.row[RW-1:0], c_ff[CW-1:0]};
      unique case (st_ff)
         tfdr_pkg::ST_IDLE: begin
            c_in = job.is_render ? '0 : job.x0;
            r_in = job.y0;
            diff_in = 1'b0;
         end
         tfdr_pkg::ST_DRAW: begin
            addr = {r_ff[RW-1:0], c_ff[CW-1:0]};
            if (c_ff + 1'b1 >= j_ff.x1) begin
               c_in = j_ff.x0;
               r_in = r_ff + 1'b1;
            end else c_in = c_ff + 1'b1;
         end
         tfdr_pkg::ST_CMP: begin
            if (rdv_ff && sh_q_ff != dr_q_ff) diff_in = 1'b1;
            c_in = (c_ff >= j_ff.cols) ? '0 : c_ff + 1'b1;
         end
         tfdr_pkg::ST_EMIT: begin
            // column counter follows the read address
            if (!stall && c_ff < j_ff.cols) c_in = c_ff + 1'b1;
         end
         tfdr_pkg::ST_WIPE: c_in = c_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= tfdr_pkg::ST_CLEAR;
         clr_ff <= '0;
         rdv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == tfdr_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         // read issued when scanning, or when emitting and not held
         rdv_ff <= (st_ff == tfdr_pkg::ST_CMP && c_ff < j_ff.cols) ||
                   (st_ff == tfdr_pkg::ST_EMIT && (stall || c_ff < j_ff.cols));
         if (emit) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
      end
      c_ff <= c_in;
      r_ff <= r_in;
      diff_ff <= diff_in;
      if (take) j_ff <= job;
      if (!stall) begin
         sh_q_ff <= shown_mem[addr];
         dr_q_ff <= draw_mem[addr];
         rdc_ff <= c_ff;
      end
      if (emit) begin
         orow_ff <= j_ff.row;
         ocol_ff <= 6'(rdc_ff);
         ochar_ff <= dr_q_ff;
         olast_ff <= rdc_ff + 1'b1 >= j_ff.cols;
      end
      if (st_ff == tfdr_pkg::ST_CLEAR) begin
         shown_mem[clr_ff[AW-1:0]] <= tfdr_pkg::BlankChar;
         draw_mem[clr_ff[AW-1:0]] <= tfdr_pkg::ClearChar;
      end else if (st_ff == tfdr_pkg::ST_DRAW && j_ff.x0 < j_ff.x1 && r_ff < j_ff.y1)
         draw_mem[addr] <= j_ff.symbol;
      else if (emit) begin
         shown_mem[{j_ff.row[RW-1:0], rdc_ff[CW-1:0]}] <= dr_q_ff;
         draw_mem[{j_ff.row[RW-1:0], rdc_ff[CW-1:0]}] <= tfdr_pkg::ClearChar;
      end else if (st_ff == tfdr_pkg::ST_WIPE && c_ff < j_ff.cols)
         draw_mem[addr] <= tfdr_pkg::ClearChar;
   end
endmodule

>>> hw/rtl/text_frame_diff_renderer_unit.sv
// Top level of the double-buffered text renderer.
// A draw writes each clipped cell in turn; a render row is first compared, then
// emitted if it changed (output stalls hold the emit) or else wiped. The back end
// takes a new item only once it is done with the last one; how long an item takes
// is set by the clipped area of a draw or the row width of a render.
// After reset a clearing pass fills both memories; the front queue takes
// up to two items meanwhile and the back end starts on them after the pass.
`include "text_frame_diff_renderer_unit_assert.svh"
module text_frame_diff_renderer_unit (
   input  logic clock,
   input  logic reset,
   tfdr_req_if.sink req,
   tfdr_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [6:0] cols_ff;
   logic [8:0] rows_ff;
   logic job_valid, job_ready, busy;
   tfdr_pkg::job_type job;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 7'd32;
         rows_ff <= 9'd32;
      end else if (wr) begin
         if (csr_paddr[2] == tfdr_pkg::RegActiveCols[0]) cols_ff <= csr_pwdata[6:0];
         else rows_ff <= csr_pwdata[8:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == tfdr_pkg::RegActiveRows[0]) csr_prdata = 32'(rows_ff);
      else csr_prdata = 32'(cols_ff);
   end

   tfdr_front u_front (
      .clock, .reset, .req,
      .active_cols(cols_ff), .active_rows(rows_ff),
      .job_valid, .job_ready, .job
   );

   tfdr_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .rsp, .busy
   );

   `TFDR_ASSERT_NEVER(a_take_nonempty, job_ready && !job_valid, "job taken from empty queue")
   `TFDR_ASSERT_IMPL(a_rsp_col, rsp.valid |-> rsp.out_col < 6'(tfdr_pkg::MaxCols), "column out of range")
   `TFDR_ASSERT_IMPL(a_busy_out, rsp.valid |-> busy, "result shown while idle")
endmodule

>>> bench/text_frame_diff_renderer_unit_tb.sv
// testbench for the double-buffered text renderer: predicted row output checked per item
`timescale 1ns / 100ps
module text_frame_diff_renderer_unit_tb;

   localparam bit CmdDraw = 1'b0;
   localparam bit CmdRender = 1'b1;
   localparam int DrainCycles = 3400;
   localparam int StallLimit = 20000;
   localparam int LongHold = 3000;

   typedef struct {
      bit command;
      logic signed [10:0] rect_x;
      logic signed [10:0] rect_y;
      logic [9:0] rect_w;
      logic [9:0] rect_h;
      logic [7:0] symbol;
      logic [7:0] row;
   } cmd_item_type;

   typedef struct {
      logic [7:0] out_row;
      logic [5:0] out_col;
      logic [7:0] out_char;
      logic last;
   } cell_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tfdr_req_if req_if ();
   tfdr_rsp_if rsp_if ();

   text_frame_diff_renderer_unit uut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // screen mirror
   logic [7:0] shown_mirror [tfdr_pkg::CellCount];
   logic [7:0] drawing_mirror [tfdr_pkg::CellCount];
   int cols_reg = 32;
   int rows_reg = 32;
   cell_out_type pending_cells [$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;

   initial begin
      req_if.valid = 1'b0;
      req_if.command = 1'b0;
      req_if.rect_x = '0;
      req_if.rect_y = '0;
      req_if.rect_w = '0;
      req_if.rect_h = '0;
      req_if.symbol = '0;
      req_if.row = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void apply_command(cmd_item_type c);
      int cols, rows, x0, x1, y0, y1, base;
      bit changed;
      cell_out_type out_item;
      cols = (cols_reg < tfdr_pkg::MaxCols) ? cols_reg : tfdr_pkg::MaxCols;
      rows = (rows_reg < tfdr_pkg::MaxRows) ? rows_reg : tfdr_pkg::MaxRows;
      if (c.command == CmdDraw) begin
         x0 = clamp(int'(c.rect_x), 0, cols);
         x1 = clamp(int'(c.rect_x) + int'(c.rect_w), 0, cols);
         y0 = clamp(int'(c.rect_y), 0, rows);
         y1 = clamp(int'(c.rect_y) + int'(c.rect_h), 0, rows);
         for (int r = y0; r < y1; r++)
            for (int k = x0; k < x1; k++)
               drawing_mirror[r * tfdr_pkg::MaxCols + k] = c.symbol;
         return;
      end
      if (int'(c.row) >= rows) return;
      base = int'(c.row) * tfdr_pkg::MaxCols;
      changed = 1'b0;
      for (int k = 0; k < cols; k++)
         if (shown_mirror[base + k] != drawing_mirror[base + k]) changed = 1'b1;
      for (int k = 0; k < cols; k++) begin
         if (changed) begin
            shown_mirror[base + k] = drawing_mirror[base + k];
            out_item.out_row = c.row;
            out_item.out_col = k[5:0];
            out_item.out_char = shown_mirror[base + k];
            out_item.last = (k == cols - 1);
            pending_cells.push_back(out_item);
         end
         drawing_mirror[base + k] = tfdr_pkg::ClearChar;
      end
   endfunction

   // receiver: random stalls plus one long hold-off on request
   int hold_count = 0;
   always @(posedge clock) begin
      if (hold_request && hold_count == 0) begin
         hold_count <= LongHold;
         rsp_if.ready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cell_out_type exp_cell;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected item: row %0d col %0d char %0h", rsp_if.out_row,
                   rsp_if.out_col, rsp_if.out_char);
            errors++;
         end else begin
            exp_cell = pending_cells.pop_front();
            if (rsp_if.out_row !== exp_cell.out_row) begin
               $error("out_row: expected %0d, got %0d", exp_cell.out_row, rsp_if.out_row);
               errors++;
            end
            if (rsp_if.out_col !== exp_cell.out_col) begin
               $error("out_col: expected %0d, got %0d", exp_cell.out_col, rsp_if.out_col);
               errors++;
            end
            if (rsp_if.out_char !== exp_cell.out_char) begin
               $error("out_char: expected %0h, got %0h", exp_cell.out_char, rsp_if.out_char);
               errors++;
            end
            if (rsp_if.last !== exp_cell.last) begin
               $error("last: expected %0b, got %0b", exp_cell.last, rsp_if.last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("** text_frame_diff_renderer_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_item(cmd_item_type c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= c.command;
      req_if.rect_x <= c.rect_x;
      req_if.rect_y <= c.rect_y;
      req_if.rect_w <= c.rect_w;
      req_if.rect_h <= c.rect_h;
      req_if.symbol <= c.symbol;
      req_if.row <= c.row;
      do @(posedge clock); while (!req_if.ready);
      apply_command(c);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(index * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == tfdr_pkg::RegActiveCols) cols_reg = value[6:0];
      else if (index == tfdr_pkg::RegActiveRows) rows_reg = value[8:0];
   endtask

   task automatic set_size(int cols, int rows);
      wait_drained();
      write_csr(tfdr_pkg::RegActiveCols, cols);
      write_csr(tfdr_pkg::RegActiveRows, rows);
   endtask

   function automatic cmd_item_type make_item(bit cmd, int x, int y, int w, int h,
                                               int sym, int row);
      cmd_item_type c;
      c.command = cmd;
      c.rect_x = x[10:0];
      c.rect_y = y[10:0];
      c.rect_w = w[9:0];
      c.rect_h = h[9:0];
      c.symbol = sym[7:0];
      c.row = row[7:0];
      return c;
   endfunction

   // mostly in-range rectangles and rows, some raw noise
   function automatic cmd_item_type random_item();
      cmd_item_type c;
      int cols, rows;
      cols = (cols_reg < tfdr_pkg::MaxCols) ? cols_reg : tfdr_pkg::MaxCols;
      rows = (rows_reg < tfdr_pkg::MaxRows) ? rows_reg : tfdr_pkg::MaxRows;
      if ($urandom_range(9) < 8) begin
         c = make_item($urandom_range(99) < 45 ? CmdRender : CmdDraw,
                       int'($urandom_range(cols + 3)) - 2, int'($urandom_range(rows + 3)) - 2,
                       $urandom_range(12), $urandom_range(8), $urandom_range(255),
                       $urandom_range(rows + 1));
      end else begin
         c = make_item($urandom_range(1), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
      end
      return c;
   endfunction

   task automatic test_directed();
      send_item(make_item(CmdDraw, 0, 0, 1023, 1023, 8'hFF, 0));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 0));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 0));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 0));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 255));
      send_item(make_item(CmdDraw, -1024, -1024, 1023, 1023, 8'h00, 0));
      send_item(make_item(CmdDraw, 1023, 1023, 1023, 1023, 8'h41, 0));
      send_item(make_item(CmdDraw, 3, 3, 0, 5, 8'h42, 0));
      send_item(make_item(CmdDraw, 3, 3, 5, 0, 8'h43, 0));
      send_item(make_item(CmdDraw, -3, -2, 10, 5, 8'h00, 0));
      for (int r = 0; r < 4; r++) send_item(make_item(CmdRender, 0, 0, 0, 0, 0, r));
      send_item(make_item(CmdDraw, 30, 31, 1023, 1023, 8'h7F, 0));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 31));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 31));
      // drawing the clear symbol over a row still holding the 0xFF fill
      send_item(make_item(CmdDraw, 0, 10, 32, 1, tfdr_pkg::ClearChar, 0));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 10));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 10));
      send_item(make_item(CmdRender, 0, 0, 0, 0, 0, 32));
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_item(random_item());
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int r = 0; r < 8; r++) send_item(make_item(CmdDraw, 0, r, 32, 1, 8'h30 + r, 0));
      hold_request = 1'b1;
      wait (hold_count > 0);
      hold_request = 1'b0;
      for (int r = 0; r < 8; r++) send_item(make_item(CmdRender, 0, 0, 0, 0, 0, r));
      // sender pauses until every cell has come out
      wait_drained();
   endtask

   task automatic test_sizes();
      set_size(1, 1);
      test_random(8, 0, 0);
      set_size(127, 511);
      test_random(10, 15, 15);
      set_size(0, 0);
      test_random(5, 0, 0);
      set_size(64, 256);
      test_random(8, 0, 78);
      set_size(5, 7);
      test_random(8, 78, 0);
      set_size(32, 32);
   endtask

   initial begin
      for (int i = 0; i < tfdr_pkg::CellCount; i++) begin
         shown_mirror[i] = tfdr_pkg::BlankChar;
         drawing_mirror[i] = tfdr_pkg::ClearChar;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(20, 0, 0);
      test_random(20, 78, 0);
      test_random(20, 0, 78);
      test_random(15, 15, 15);
      test_backpressure();
      test_sizes();
      test_random(10, 15, 15);
      wait_drained();
      if (errors == 0) begin
         $display("** text_frame_diff_renderer_unit: PASSED **");
      end else begin
         $display("** text_frame_diff_renderer_unit: FAILED **");
      end
      $finish;
   end
endmodule

>>> text_frame_diff_renderer_unit.f
+incdir+hw/rtl
hw/rtl/tfdr_pkg.sv
hw/rtl/tfdr_req_if.sv
hw/rtl/tfdr_front.sv
hw/rtl/tfdr_back.sv
hw/rtl/text_frame_diff_renderer_unit.sv
bench/text_frame_diff_renderer_unit_tb.sv
